FILE: rtl/idi_pkg.sv
// Package for the inverse distance interpolator: sizes, payload structs,
// datapath command codes and the controller-datapath command/status structs.
// No dependencies.
package idi_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int K_W         = $clog2(MAX_ENTRIES + 1);
    localparam int ACC_W       = 98 + $clog2(MAX_ENTRIES);
    localparam int IT_W        = $clog2(ACC_W + 1);
    localparam int SQRT_STEPS  = 34;
    localparam int WDIV_STEPS  = 80;

    localparam int CNT_W       = 6;
    localparam int POW_W       = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER        = 1'd1;
    localparam logic [CNT_W-1:0]     ENTRY_COUNT_RST  = 6'd21;
    localparam logic [POW_W-1:0]     POWER_RST        = 4'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [4:0]         entry_index;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] value_in_x;
        logic signed [31:0] value_in_y;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_out_x;
        logic signed [31:0] value_out_y;
        logic               exact_hit;
        logic               saturated;
    } t_out_item;

    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_DX    = 3'd1,
        MUL_DY    = 3'd2,
        MUL_VX_LO = 3'd3,
        MUL_VX_HI = 3'd4,
        MUL_VY_LO = 3'd5,
        MUL_VY_HI = 3'd6
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_SQ_SET = 3'd1,
        ACC_SQ_ADD = 3'd2,
        ACC_X_LO   = 3'd3,
        ACC_X_HI   = 3'd4,
        ACC_Y_LO   = 3'd5,
        ACC_Y_HI   = 3'd6
    } t_acc_sel;

    typedef struct packed {
        logic             load_we;
        logic             q_start;
        logic [IDX_W-1:0] rd_addr;
        logic             diff;
        t_mul_sel         mul_sel;
        t_acc_sel         acc_sel;
        logic             sqrt_step;
        logic             w_set;
        logic             wdiv_init;
        logic             div_step;
        logic             w_end;
        logic             norm_add;
        logic             fdiv_x_init;
        logic             fdiv_y_init;
        logic             fx_end;
        logic             fy_end;
        logic             out_zero;
        logic             out_hit;
    } t_dp_cmd;

    typedef struct packed {
        logic d_zero;
        logic q_ovf;
        logic norm_zero;
    } t_dp_sts;

endpackage

FILE: rtl/idi_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module idi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/idi_datapath.sv
// Datapath: point table, distance, square root, weight and final division,
// weighted sums. Driven cycle by cycle by the controller.
// Depends on idi_pkg and idi_ram.
module idi_datapath
    import idi_pkg::*;
(
    input  logic      i_clk,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_item,
    output t_dp_sts   o_sts,
    output t_out_item o_result
);

    logic [127:0]       rdata;
    logic [31:0]        tb_px, tb_py, tb_vx, tb_vy;

    logic [31:0]        r_qx, r_qy, r_vx, r_vy;
    logic [32:0]        r_dx, r_dy;
    logic [65:0]        r_prod;
    logic [67:0]        r_sq;
    logic [36:0]        r_rem;
    logic [33:0]        r_root;
    logic [63:0]        r_w;
    logic [63:0]        r_norm;
    logic [ACC_W-1:0]   r_sx, r_sy;
    logic [ACC_W-1:0]   r_dvd;
    logic [63:0]        r_drem, r_dvs, r_q;
    logic               r_qovf, r_neg, r_sat;
    t_out_item          r_out;

    logic signed [32:0] dxs, dys;
    logic [32:0]        vxm, vym, ma, mb;
    logic [ACC_W-1:0]   term;
    logic [36:0]        sq_cand, sq_trial;
    logic [64:0]        dv_t;
    logic               dv_ge;
    logic [64:0]        norm_sum;
    logic [31:0]        fin_val;
    logic               fin_clamp;

    idi_ram #(
        .WIDTH (128),
        .DEPTH (MAX_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_we),
        .i_waddr (IDX_W'(i_item.entry_index)),
        .i_wdata ({i_item.point_x, i_item.point_y, i_item.value_in_x, i_item.value_in_y}),
        .i_raddr (i_cmd.rd_addr),
        .o_rdata (rdata)
    );

    assign {tb_px, tb_py, tb_vx, tb_vy} = rdata;

    assign dxs = {r_qx[31], r_qx} - {tb_px[31], tb_px};
    assign dys = {r_qy[31], r_qy} - {tb_py[31], tb_py};
    assign vxm = r_vx[31] ? (33'd0 - {1'b1, r_vx}) : {1'b0, r_vx};
    assign vym = r_vy[31] ? (33'd0 - {1'b1, r_vy}) : {1'b0, r_vy};

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_DX:    begin ma = r_dx; mb = r_dx;                 end
            MUL_DY:    begin ma = r_dy; mb = r_dy;                 end
            MUL_VX_LO: begin ma = vxm;  mb = {1'b0, r_w[31:0]};    end
            MUL_VX_HI: begin ma = vxm;  mb = {1'b0, r_w[63:32]};   end
            MUL_VY_LO: begin ma = vym;  mb = {1'b0, r_w[31:0]};    end
            MUL_VY_HI: begin ma = vym;  mb = {1'b0, r_w[63:32]};   end
            default:   begin ma = '0;   mb = '0;                   end
        endcase
    end

    always_comb begin
        case (i_cmd.acc_sel)
            ACC_X_HI, ACC_Y_HI: term = ACC_W'(r_prod) << 32;
            default:            term = ACC_W'(r_prod);
        endcase
    end

    assign sq_cand  = {r_rem[34:0], r_sq[67:66]};
    assign sq_trial = {1'b0, r_root, 2'b01};

    assign dv_t  = {r_drem, r_dvd[ACC_W-1]};
    assign dv_ge = dv_t >= {1'b0, r_dvs};

    assign norm_sum = {1'b0, r_norm} + {1'b0, r_w};

    always_comb begin
        if (r_neg) begin
            fin_clamp = r_qovf || (r_q > 64'h0000_0000_8000_0000);
            fin_val   = fin_clamp ? 32'h8000_0000 : (32'd0 - r_q[31:0]);
        end else begin
            fin_clamp = r_qovf || (r_q > 64'h0000_0000_7FFF_FFFF);
            fin_val   = fin_clamp ? 32'h7FFF_FFFF : r_q[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_start) begin
            r_qx   <= i_item.point_x;
            r_qy   <= i_item.point_y;
            r_sx   <= '0;
            r_sy   <= '0;
            r_norm <= '0;
            r_sat  <= 1'b0;
        end
        if (i_cmd.diff) begin
            r_dx <= dxs[32] ? 33'(-dxs) : 33'(dxs);
            r_dy <= dys[32] ? 33'(-dys) : 33'(dys);
            r_vx <= tb_vx;
            r_vy <= tb_vy;
        end
        if (i_cmd.mul_sel != MUL_NONE) begin
            r_prod <= ma * mb;
        end
        case (i_cmd.acc_sel)
            ACC_SQ_SET: r_sq <= 68'(r_prod);
            ACC_SQ_ADD: begin
                r_sq   <= r_sq + 68'(r_prod);
                r_rem  <= '0;
                r_root <= '0;
            end
            ACC_X_LO, ACC_X_HI: r_sx <= r_vx[31] ? (r_sx - term) : (r_sx + term);
            ACC_Y_LO, ACC_Y_HI: r_sy <= r_vy[31] ? (r_sy - term) : (r_sy + term);
            default: ;
        endcase
        if (i_cmd.sqrt_step) begin
            r_sq <= {r_sq[65:0], 2'b00};
            if (sq_cand >= sq_trial) begin
                r_rem  <= sq_cand - sq_trial;
                r_root <= {r_root[32:0], 1'b1};
            end else begin
                r_rem  <= sq_cand;
                r_root <= {r_root[32:0], 1'b0};
            end
        end
        if (i_cmd.w_set) begin
            r_w <= 64'h0000_0001_0000_0000;
        end
        if (i_cmd.wdiv_init) begin
            r_dvd  <= {r_w, (ACC_W-64)'(0)};
            r_dvs  <= {30'd0, r_root};
            r_drem <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
        end
        if (i_cmd.fdiv_x_init) begin
            r_dvd  <= r_sx[ACC_W-1] ? (ACC_W'(0) - r_sx) : r_sx;
            r_neg  <= r_sx[ACC_W-1];
            r_dvs  <= r_norm;
            r_drem <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
        end
        if (i_cmd.fdiv_y_init) begin
            r_dvd  <= r_sy[ACC_W-1] ? (ACC_W'(0) - r_sy) : r_sy;
            r_neg  <= r_sy[ACC_W-1];
            r_dvs  <= r_norm;
            r_drem <= '0;
            r_q    <= '0;
            r_qovf <= 1'b0;
        end
        if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[ACC_W-2:0], 1'b0};
            r_drem <= dv_ge ? 64'(dv_t - {1'b0, r_dvs}) : dv_t[63:0];
            r_q    <= {r_q[62:0], dv_ge};
            r_qovf <= r_qovf | r_q[63];
        end
        if (i_cmd.w_end) begin
            if (r_qovf) begin
                r_w   <= '1;
                r_sat <= 1'b1;
            end else begin
                r_w <= r_q;
            end
        end
        if (i_cmd.norm_add) begin
            if (norm_sum[64]) begin
                r_norm <= '1;
                r_sat  <= 1'b1;
            end else begin
                r_norm <= norm_sum[63:0];
            end
        end
        if (i_cmd.fx_end) begin
            r_out.value_out_x <= fin_val;
            r_sat             <= r_sat | fin_clamp;
        end
        if (i_cmd.fy_end) begin
            r_out.value_out_y <= fin_val;
            r_out.exact_hit   <= 1'b0;
            r_out.saturated   <= r_sat | fin_clamp;
        end
        if (i_cmd.out_zero) begin
            r_out.value_out_x <= '0;
            r_out.value_out_y <= '0;
            r_out.exact_hit   <= 1'b0;
            r_out.saturated   <= r_sat;
        end
        if (i_cmd.out_hit) begin
            r_out.value_out_x <= r_vx;
            r_out.value_out_y <= r_vy;
            r_out.exact_hit   <= 1'b1;
            r_out.saturated   <= 1'b0;
        end
    end

    assign o_sts.d_zero    = (r_root == '0);
    assign o_sts.q_ovf     = r_qovf;
    assign o_sts.norm_zero = (r_norm == '0);
    assign o_result        = r_out;

endmodule

FILE: rtl/idi_ctrl.sv
// Controller: configuration registers, walk over table entries and sequencing
// of the datapath steps. Depends on idi_pkg.
module idi_ctrl
    import idi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_dp_sts               i_sts,
    output t_dp_cmd               o_cmd,
    output logic                  o_strobe
);

    typedef enum logic [23:0] {
        S_IDLE = 24'h000001, S_RD   = 24'h000002, S_DIFF = 24'h000004,
        S_SQX  = 24'h000008, S_SQY  = 24'h000010, S_SQADD = 24'h000020,
        S_ROOT = 24'h000040, S_WCHK = 24'h000080, S_WINIT = 24'h000100,
        S_WDIV = 24'h000200, S_WEND = 24'h000400, S_MXL  = 24'h000800,
        S_MXH  = 24'h001000, S_MYL  = 24'h002000, S_MYH  = 24'h004000,
        S_ACCY = 24'h008000, S_FIN  = 24'h010000, S_FXI  = 24'h020000,
        S_FXD  = 24'h040000, S_FXE  = 24'h080000, S_FYI  = 24'h100000,
        S_FYD  = 24'h200000, S_FYE  = 24'h400000, S_DONE = 24'h800000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [POW_W-1:0] r_power;
    logic [K_W-1:0]   r_k, n_k, r_n, n_n;
    logic [IT_W-1:0]  r_it, n_it;
    logic [POW_W-1:0] r_pw, n_pw;
    logic             accept;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE) && (r_state != S_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= ENTRY_COUNT_RST;
            r_power <= POWER_RST;
            r_k     <= '0;
            r_n     <= '0;
            r_it    <= '0;
            r_pw    <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_n     <= n_n;
            r_it    <= n_it;
            r_pw    <= n_pw;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ENTRY_COUNT: r_count <= i_cfg_data;
                    CFG_POWER:       r_power <= i_cfg_data[POW_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_n     = r_n;
        n_it    = r_it;
        n_pw    = r_pw;
        o_cmd   = '0;
        o_cmd.mul_sel = MUL_NONE;
        o_cmd.acc_sel = ACC_NONE;
        o_cmd.rd_addr = r_k[IDX_W-1:0];
        case (r_state)
            S_IDLE, S_DONE: begin
                n_state = S_IDLE;
                if (accept) begin
                    if (i_item.cmd == CMD_QUERY) begin
                        o_cmd.q_start = 1'b1;
                        n_k = '0;
                        if (int'(r_count) > MAX_ENTRIES) begin
                            n_n = K_W'(MAX_ENTRIES);
                        end else begin
                            n_n = K_W'(r_count);
                        end
                        n_state = (r_count == '0) ? S_FIN : S_RD;
                    end else begin
                        o_cmd.load_we = (int'(i_item.entry_index) < MAX_ENTRIES);
                    end
                end
            end
            S_RD:   n_state = S_DIFF;
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_SQX;
            end
            S_SQX: begin
                o_cmd.mul_sel = MUL_DX;
                n_state       = S_SQY;
            end
            S_SQY: begin
                o_cmd.mul_sel = MUL_DY;
                o_cmd.acc_sel = ACC_SQ_SET;
                n_state       = S_SQADD;
            end
            S_SQADD: begin
                o_cmd.acc_sel = ACC_SQ_ADD;
                n_it          = '0;
                n_state       = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_it            = r_it + 1'b1;
                if (r_it == IT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_WCHK;
                end
            end
            S_WCHK: begin
                if (i_sts.d_zero && (r_power != '0)) begin
                    o_cmd.out_hit = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.w_set = 1'b1;
                    n_pw        = '0;
                    n_state     = (r_power == '0) ? S_MXL : S_WINIT;
                end
            end
            S_WINIT: begin
                o_cmd.wdiv_init = 1'b1;
                n_it            = '0;
                n_state         = S_WDIV;
            end
            S_WDIV: begin
                o_cmd.div_step = 1'b1;
                n_it           = r_it + 1'b1;
                if (r_it == IT_W'(WDIV_STEPS - 1)) begin
                    n_state = S_WEND;
                end
            end
            S_WEND: begin
                o_cmd.w_end = 1'b1;
                n_pw        = r_pw + 1'b1;
                if (i_sts.q_ovf || (n_pw == r_power)) begin
                    n_state = S_MXL;
                end else begin
                    n_state = S_WINIT;
                end
            end
            S_MXL: begin
                o_cmd.mul_sel = MUL_VX_LO;
                n_state       = S_MXH;
            end
            S_MXH: begin
                o_cmd.mul_sel = MUL_VX_HI;
                o_cmd.acc_sel = ACC_X_LO;
                n_state       = S_MYL;
            end
            S_MYL: begin
                o_cmd.mul_sel = MUL_VY_LO;
                o_cmd.acc_sel = ACC_X_HI;
                n_state       = S_MYH;
            end
            S_MYH: begin
                o_cmd.mul_sel = MUL_VY_HI;
                o_cmd.acc_sel = ACC_Y_LO;
                n_state       = S_ACCY;
            end
            S_ACCY: begin
                o_cmd.acc_sel  = ACC_Y_HI;
                o_cmd.norm_add = 1'b1;
                n_k            = r_k + 1'b1;
                n_state        = (n_k == r_n) ? S_FIN : S_RD;
            end
            S_FIN: begin
                if (i_sts.norm_zero) begin
                    o_cmd.out_zero = 1'b1;
                    n_state        = S_DONE;
                end else begin
                    n_state = S_FXI;
                end
            end
            S_FXI: begin
                o_cmd.fdiv_x_init = 1'b1;
                n_it              = '0;
                n_state           = S_FXD;
            end
            S_FXD: begin
                o_cmd.div_step = 1'b1;
                n_it           = r_it + 1'b1;
                if (r_it == IT_W'(ACC_W - 1)) begin
                    n_state = S_FXE;
                end
            end
            S_FXE: begin
                o_cmd.fx_end = 1'b1;
                n_state      = S_FYI;
            end
            S_FYI: begin
                o_cmd.fdiv_y_init = 1'b1;
                n_it              = '0;
                n_state           = S_FYD;
            end
            S_FYD: begin
                o_cmd.div_step = 1'b1;
                n_it           = r_it + 1'b1;
                if (r_it == IT_W'(ACC_W - 1)) begin
                    n_state = S_FYE;
                end
            end
            S_FYE: begin
                o_cmd.fy_end = 1'b1;
                n_state      = S_DONE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_strobe = (r_state == S_DONE);

endmodule

FILE: rtl/inverse_distance_interpolator.sv
// Top level of the inverse distance interpolator: controller and datapath.
// Depends on idi_pkg, idi_ctrl, idi_datapath.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-----------------------------
//  item in   | start, busy                | i_item (t_in_item)
//  result    | o_strobe (one cycle)       | o_result (t_out_item)
//  config    | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
// A load writes its table entry when accepted. A query walks each entry through
// a serial square root and, per power step, the weight divider at one bit a
// cycle, then a check, two final divisions and a result state. An exact hit at
// a nonzero power ends the walk at that entry. All divisions share one divider.
// Reset restores an entry count of 21 and a power of 2; the table is not cleared.
// The result strobe lasts one cycle, the receiver cannot stall it, and a new
// item may be taken in that cycle.
module inverse_distance_interpolator
    import idi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_strobe,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    idi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd),
        .o_strobe    (o_strobe)
    );

    idi_datapath u_dp (
        .i_clk    (i_clk),
        .i_cmd    (dp_cmd),
        .i_item   (i_item),
        .o_sts    (dp_sts),
        .o_result (o_result)
    );

endmodule
